[sv/bsa_pkg.sv]
package bsa_pkg;

  localparam int unsigned MaxSectors = 8192;
  localparam int unsigned MaxRequest = 64;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned MapWords   = MaxSectors / WordBits;
  localparam int unsigned WordAw     = $clog2(MapWords);
  localparam int unsigned BitAw      = $clog2(WordBits);
  localparam int unsigned SectorW    = 13;
  localparam int unsigned CountW     = 14;
  localparam int unsigned ReqW       = 7;
  localparam int unsigned OpW        = 2;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 14;

  localparam logic [OpW-1:0] OpFormat  = 2'd0;
  localparam logic [OpW-1:0] OpAlloc   = 2'd1;
  localparam logic [OpW-1:0] OpRelease = 2'd2;

  localparam logic [StatusW-1:0] StatOk         = 2'd0;
  localparam logic [StatusW-1:0] StatNoSpace    = 2'd1;
  localparam logic [StatusW-1:0] StatBadRelease = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgSectorCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMapSector   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRootSector  = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]     operation;
    logic [ReqW-1:0]    request_count;
    logic [SectorW-1:0] sector;
  } req_t;

  typedef struct packed {
    logic [SectorW-1:0] granted_sector;
    logic [StatusW-1:0] status;
    logic               last;
  } res_t;

endpackage

[sv/bsa_ram.sv]
module bsa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/bitmap_sector_allocator_top.sv]
// channel   | signals                                   | transfer when
// ----------+-------------------------------------------+------------------------
// command   | start, busy, req_i                        | start && !busy
// result    | res_valid_o, res_o                        | res_valid_o (one cycle)
// config    | cfg_valid_i, cfg_ready_o, cfg_index_i/data | cfg_valid_i && cfg_ready_o
//
// format: one map word written per cycle through the bitmap memory
// allocate of n sectors: per sector a group pick, a word pick and read, then modify and write
// release: read, then modify and write; a rejected or zero allocate request is answered from idle
// after reset the map is rebuilt by a format sweep with busy high, no result
// results cannot be stalled; each is shown for exactly one cycle
module bitmap_sector_allocator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bsa_pkg::req_t                 req_i,
  output logic                          res_valid_o,
  output bsa_pkg::res_t                 res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bsa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bsa_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bsa_pkg::*;

  localparam int unsigned GroupSize = 16;
  localparam int unsigned Groups    = MapWords / GroupSize;
  localparam int unsigned GroupAw   = $clog2(Groups);
  localparam int unsigned InGrpAw   = $clog2(GroupSize);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_FORMAT  = 6'b000010,
    S_GROUP   = 6'b000100,
    S_WORD    = 6'b001000,
    S_ALLOC   = 6'b010000,
    S_RELEASE = 6'b100000
  } state_e;

  function automatic logic [GroupAw-1:0] first_clear_grp(input logic [Groups-1:0] v);
    logic [GroupAw-1:0] r;
    r = '0;
    for (int i = Groups - 1; i >= 0; i--) begin
      if (!v[i]) r = GroupAw'(i);
    end
    return r;
  endfunction

  function automatic logic [InGrpAw-1:0] first_clear_in(input logic [GroupSize-1:0] v);
    logic [InGrpAw-1:0] r;
    r = '0;
    for (int i = GroupSize - 1; i >= 0; i--) begin
      if (!v[i]) r = InGrpAw'(i);
    end
    return r;
  endfunction

  function automatic logic [BitAw-1:0] first_clear_bit(input logic [WordBits-1:0] v);
    logic [BitAw-1:0] r;
    r = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (!v[i]) r = BitAw'(i);
    end
    return r;
  endfunction

  state_e              state_q, state_d;
  logic [CountW-1:0]   sector_count_q;
  logic [SectorW-1:0]  map_sector_q, root_sector_q;
  logic [CountW-1:0]   fmt_count_q, fmt_count_d;
  logic [SectorW-1:0]  fmt_map_q, fmt_map_d, fmt_root_q, fmt_root_d;
  logic                fmt_reply_q, fmt_reply_d;
  logic [WordAw-1:0]   sweep_q, sweep_d;
  logic [MapWords-1:0] full_q, full_d;
  logic [CountW-1:0]   free_q, free_d;
  logic [ReqW-1:0]     remain_q, remain_d;
  logic [GroupAw-1:0]  grp_q, grp_d;
  logic [WordAw-1:0]   word_q, word_d;
  logic [BitAw-1:0]    bit_q, bit_d;
  logic                range_bad_q, range_bad_d;
  res_t                res_q, res_d;
  logic                res_valid_q, res_valid_d;

  logic                ram_we, ram_re;
  logic [WordAw-1:0]   ram_waddr, ram_raddr;
  logic [WordBits-1:0] ram_wdata, ram_rdata;

  logic [CountW-1:0]   eff_count;
  logic [ReqW-1:0]     req_sat;
  logic [Groups-1:0]   grp_full;
  logic [WordBits-1:0] fmt_word;
  logic                fmt_map_ok, fmt_root_ok;
  logic [CountW-1:0]   fmt_free;
  logic [CountW-1:0]   fmt_sec;
  logic [InGrpAw-1:0]  in_grp;
  logic [BitAw-1:0]    alloc_bit;
  logic [WordBits-1:0] alloc_word;

  bsa_ram #(
    .Width (WordBits),
    .Depth (MapWords)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign eff_count = (sector_count_q > CountW'(MaxSectors)) ? CountW'(MaxSectors)
                                                            : sector_count_q;
  assign req_sat   = (req_i.request_count > ReqW'(MaxRequest)) ? ReqW'(MaxRequest)
                                                               : req_i.request_count;

  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      grp_full[g] = &full_q[g*GroupSize +: GroupSize];
    end
  end

  assign fmt_map_ok  = {1'b0, fmt_map_q} < fmt_count_q;
  assign fmt_root_ok = ({1'b0, fmt_root_q} < fmt_count_q) && (fmt_root_q != fmt_map_q);
  assign fmt_free    = fmt_count_q - CountW'(fmt_map_ok) - CountW'(fmt_root_ok);

  always_comb begin
    for (int b = 0; b < WordBits; b++) begin
      fmt_sec     = CountW'({sweep_q, BitAw'(b)});
      fmt_word[b] = (fmt_sec >= fmt_count_q)
                 || (fmt_sec == {1'b0, fmt_map_q} && fmt_map_ok)
                 || (fmt_sec == {1'b0, fmt_root_q} && fmt_root_ok);
    end
  end

  assign in_grp     = first_clear_in(full_q[grp_q*GroupSize +: GroupSize]);
  assign alloc_bit  = first_clear_bit(ram_rdata);
  assign alloc_word = ram_rdata | (WordBits'(1) << alloc_bit);

  always_comb begin
    state_d     = state_q;
    fmt_count_d = fmt_count_q;
    fmt_map_d   = fmt_map_q;
    fmt_root_d  = fmt_root_q;
    fmt_reply_d = fmt_reply_q;
    sweep_d     = sweep_q;
    full_d      = full_q;
    free_d      = free_q;
    remain_d    = remain_q;
    grp_d       = grp_q;
    word_d      = word_q;
    bit_d       = bit_q;
    range_bad_d = range_bad_q;
    res_d       = '{granted_sector: '0, status: StatOk, last: 1'b1};
    res_valid_d = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = word_q;
    ram_wdata   = alloc_word;
    ram_re      = 1'b0;
    ram_raddr   = word_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          priority if (req_i.operation == OpFormat) begin
            fmt_count_d = eff_count;
            fmt_map_d   = map_sector_q;
            fmt_root_d  = root_sector_q;
            fmt_reply_d = 1'b1;
            sweep_d     = '0;
            state_d     = S_FORMAT;
          end else if (req_i.operation == OpAlloc) begin
            priority if (req_sat == '0) begin
              res_valid_d = 1'b1;
            end else if (free_q < CountW'(req_sat)) begin
              res_valid_d = 1'b1;
              res_d.status = StatNoSpace;
            end else begin
              remain_d = req_sat;
              state_d  = S_GROUP;
            end
          end else if (req_i.operation == OpRelease) begin
            range_bad_d = {1'b0, req_i.sector} >= eff_count;
            word_d      = req_i.sector[SectorW-1 -: WordAw];
            bit_d       = req_i.sector[BitAw-1:0];
            ram_re      = 1'b1;
            ram_raddr   = req_i.sector[SectorW-1 -: WordAw];
            state_d     = S_RELEASE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_FORMAT: begin
        ram_we          = 1'b1;
        ram_waddr       = sweep_q;
        ram_wdata       = fmt_word;
        full_d[sweep_q] = &fmt_word;
        sweep_d         = sweep_q + 1'b1;
        if (sweep_q == WordAw'(MapWords - 1)) begin
          free_d      = fmt_free;
          res_valid_d = fmt_reply_q;
          state_d     = S_IDLE;
        end
      end
      S_GROUP: begin
        grp_d   = first_clear_grp(grp_full);
        state_d = S_WORD;
      end
      S_WORD: begin
        word_d    = {grp_q, in_grp};
        ram_re    = 1'b1;
        ram_raddr = {grp_q, in_grp};
        state_d   = S_ALLOC;
      end
      S_ALLOC: begin
        ram_we         = 1'b1;
        ram_wdata      = alloc_word;
        full_d[word_q] = &alloc_word;
        free_d         = free_q - 1'b1;
        remain_d       = remain_q - 1'b1;
        res_valid_d    = 1'b1;
        res_d.granted_sector = {word_q, alloc_bit};
        res_d.last     = (remain_q == ReqW'(1));
        state_d        = (remain_q == ReqW'(1)) ? S_IDLE : S_GROUP;
      end
      S_RELEASE: begin
        res_valid_d = 1'b1;
        if (range_bad_q || !ram_rdata[bit_q]) begin
          res_d.status = StatBadRelease;
        end else begin
          ram_we         = 1'b1;
          ram_wdata      = ram_rdata & ~(WordBits'(1) << bit_q);
          full_d[word_q] = 1'b0;
          free_d         = free_q + 1'b1;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_FORMAT;
      sector_count_q <= CountW'(MaxSectors);
      map_sector_q   <= SectorW'(0);
      root_sector_q  <= SectorW'(1);
      fmt_count_q    <= CountW'(MaxSectors);
      fmt_map_q      <= SectorW'(0);
      fmt_root_q     <= SectorW'(1);
      fmt_reply_q    <= 1'b0;
      sweep_q        <= '0;
      full_q         <= '0;
      free_q         <= '0;
      remain_q       <= '0;
      res_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      fmt_count_q <= fmt_count_d;
      fmt_map_q   <= fmt_map_d;
      fmt_root_q  <= fmt_root_d;
      fmt_reply_q <= fmt_reply_d;
      sweep_q     <= sweep_d;
      full_q      <= full_d;
      free_q      <= free_d;
      remain_q    <= remain_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgSectorCount: sector_count_q <= cfg_data_i[CountW-1:0];
          CfgMapSector:   map_sector_q   <= cfg_data_i[SectorW-1:0];
          CfgRootSector:  root_sector_q  <= cfg_data_i[SectorW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q       <= grp_d;
    word_q      <= word_d;
    bit_q       <= bit_d;
    range_bad_q <= range_bad_d;
    res_q       <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[sv/bsa_checker.sv]
module bsa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input bsa_pkg::req_t                 req_i,
  input logic                          res_valid_o,
  input bsa_pkg::res_t                 res_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [bsa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input logic [bsa_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bsa_pkg::*;

  logic unused_cfg;
  assign unused_cfg = cfg_valid_i ^ cfg_ready_o ^ (^cfg_index_i) ^ (^cfg_data_i);

  // failures and rejects are always single results
  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != StatOk |-> res_o.last)
    else $error("failure result not marked last");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != StatOk |-> res_o.granted_sector == '0)
    else $error("failure result carries a sector");

  // more grants to come keep the block busy
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("idle between grants of one request");

  a_format_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.operation == OpFormat |=> busy)
    else $error("format did not start a sweep");

  a_release_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.operation == OpRelease |=> busy && !res_valid_o)
    else $error("release did not read the map");

endmodule

bind bitmap_sector_allocator_top bsa_checker u_bsa_checker (.*);
